// ----- hdl/kmer_pkg.sv -----
// Shared types and constants for the key matrix edge/auto-repeat unit.
// No dependencies; imported by every module of the block.
package kmer_pkg;

    localparam int ROWS     = 8;
    localparam int COLS     = 6;
    localparam int MATRIX_W = ROWS * COLS;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int TIMER_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIMER_W-1:0] DELAY_RESET = TIMER_W'(32);
    localparam logic [TIMER_W-1:0] RATE_RESET  = TIMER_W'(2);

    typedef logic [COLS-1:0] t_row;
    typedef t_row [ROWS-1:0] t_rows;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODIFIER_MASK = 2'd0,
        CFG_REPEAT_DELAY  = 2'd1,
        CFG_REPEAT_RATE   = 2'd2
    } t_cfg_idx;

    // Detection result for one snapshot
    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             held;
    } t_det;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic [MATRIX_W-1:0] modifier_mask;
        logic [TIMER_W-1:0]  repeat_delay;
        logic [TIMER_W-1:0]  repeat_rate;
    } t_cfg;

endpackage

// ----- hdl/kmer_if.sv -----
// Handshake channel interfaces for the key matrix unit.
// Depends on kmer_pkg for field widths.
interface kmer_in_if import kmer_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MATRIX_W-1:0] matrix_rows;

    modport source (output valid, output matrix_rows, input ready);
    modport sink   (input valid, input matrix_rows, output ready);
endinterface

interface kmer_out_if import kmer_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             key_down;
    logic [ROW_W-1:0] key_row;
    logic [COL_W-1:0] key_col;

    modport source (output valid, output key_down, output key_row, output key_col,
                    input ready);
    modport sink   (input valid, input key_down, input key_row, input key_col,
                    output ready);
endinterface

interface kmer_cfg_if import kmer_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MATRIX_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/kmer_cfg_regs.sv -----
// Configuration register file: modifier mask, repeat delay, repeat rate.
// Depends on kmer_pkg.
module kmer_cfg_regs import kmer_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [MATRIX_W-1:0]  i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modifier_mask <= '0;
            r_cfg.repeat_delay  <= DELAY_RESET;
            r_cfg.repeat_rate   <= RATE_RESET;
        end else if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_MODIFIER_MASK: r_cfg.modifier_mask <= i_data;
                CFG_REPEAT_DELAY:  r_cfg.repeat_delay  <= i_data[TIMER_W-1:0];
                CFG_REPEAT_RATE:   r_cfg.repeat_rate   <= i_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/kmer_detect.sv -----
// New key-down detection and priority select over one snapshot.
// Depends on kmer_pkg.
module kmer_detect import kmer_pkg::*; (
    input  logic [MATRIX_W-1:0] i_snap,
    input  t_rows               i_prev,
    input  logic [MATRIX_W-1:0] i_modifier_mask,
    output t_det                o_det
);

    t_rows w_pressed;
    t_rows w_fresh;
    t_det  w_det;

    // Pressed keys (active low) and keys newly pressed against the stored frame
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_pressed[r] = ~i_snap[r*COLS +: COLS];
            w_fresh[r]   = w_pressed[r] & i_prev[r];
        end
    end

    // Flag any held non-modifier key; pick the highest row with a new press, lowest column inside it
    always_comb begin
        w_det = '0;
        for (int r = 0; r < ROWS; r++) begin
            if ((w_pressed[r] & ~i_modifier_mask[r*COLS +: COLS]) != '0) begin
                w_det.held = 1'b1;
            end
            if (w_fresh[r] != '0) begin
                w_det.found = 1'b1;
                w_det.row   = ROW_W'(r);
                for (int c = COLS - 1; c >= 0; c--) begin
                    if (w_fresh[r][c]) begin
                        w_det.col = COL_W'(c);
                    end
                end
            end
        end
    end

    assign o_det = w_det;

endmodule

// ----- hdl/kmer_repeat.sv -----
// Stored previous snapshot and auto-repeat timer.
// Depends on kmer_pkg.
module kmer_repeat import kmer_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [MATRIX_W-1:0] i_snap,
    input  logic                i_held,
    input  logic [TIMER_W-1:0]  i_delay,
    input  logic [TIMER_W-1:0]  i_rate,
    output t_rows               o_prev
);

    t_rows              r_prev;
    t_rows              n_prev;
    logic [TIMER_W-1:0] r_timer;
    logic [TIMER_W-1:0] n_timer;
    logic [TIMER_W-1:0] w_start;
    logic [TIMER_W-1:0] w_dec;

    // Start, count down, and reload on expiry
    always_comb begin
        if (!i_held) begin
            w_start = '0;
        end else if (r_timer == '0) begin
            w_start = i_delay;
        end else begin
            w_start = r_timer;
        end
        w_dec = w_start - TIMER_W'(1);

        for (int r = 0; r < ROWS; r++) begin
            n_prev[r] = i_snap[r*COLS +: COLS];
        end
        n_timer = '0;
        if (w_start != '0) begin
            n_timer = w_dec;
            if (w_dec == '0) begin
                n_prev  = '1;
                n_timer = i_rate;
            end
        end
    end

    // Advance state once per transfer through the compute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '1;
            r_timer <= '0;
        end else if (i_step) begin
            r_prev  <= n_prev;
            r_timer <= n_timer;
        end
    end

    assign o_prev = r_prev;

endmodule

// ----- hdl/key_matrix_edge_repeat_unit.sv -----
// Key matrix scanner with new-key detection and auto-repeat.
// A snapshot passes through the input register, then the result register.
// Throughput: one snapshot per cycle while the sink does not stall; input ready follows the result register's ready.
// Reset (synchronous, active low): pipeline empty, stored frame all released,
// repeat timer stopped, modifier mask 0, repeat delay 32, repeat rate 2.
module key_matrix_edge_repeat_unit import kmer_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmer_in_if.sink    i_in,
    kmer_cfg_if.sink   i_cfg,
    kmer_out_if.source o_out
);

    logic                r_s1_vld;
    logic [MATRIX_W-1:0] r_s1_snap;
    logic                r_out_vld;
    logic                r_out_key_down;
    logic [ROW_W-1:0]    r_out_key_row;
    logic [COL_W-1:0]    r_out_key_col;
    logic                w_adv;
    t_cfg                w_cfg;
    t_rows               w_prev;
    t_det                w_det;

    // Configuration channel never stalls
    assign i_cfg.ready = 1'b1;

    kmer_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    // Advance the compute stage when the result register is free or drains
    assign w_adv      = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_snap <= i_in.matrix_rows;
        end
    end

    kmer_detect u_detect (
        .i_snap          (r_s1_snap),
        .i_prev          (w_prev),
        .i_modifier_mask (w_cfg.modifier_mask),
        .o_det           (w_det)
    );

    kmer_repeat u_repeat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_snap  (r_s1_snap),
        .i_held  (w_det.held),
        .i_delay (w_cfg.repeat_delay),
        .i_rate  (w_cfg.repeat_rate),
        .o_prev  (w_prev)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_key_down <= w_det.found;
            r_out_key_row  <= w_det.row;
            r_out_key_col  <= w_det.col;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.key_down = r_out_key_down;
    assign o_out.key_row  = r_out_key_row;
    assign o_out.key_col  = r_out_key_col;

endmodule

// ----- hdl/kmer_checker.sv -----
// Port-level checks for key_matrix_edge_repeat_unit, attached by bind.
// Depends on kmer_pkg and the top level's port names.
module kmer_checker import kmer_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_key_down,
    input logic [ROW_W-1:0] i_key_row,
    input logic [COL_W-1:0] i_key_col
);

    // A result without an event carries position zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_key_down) |-> (i_key_row == '0 && i_key_col == '0))
        else $error("kmer: empty result carries a position");

    // Column stays inside the matrix
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_key_col < COL_W'(COLS)))
        else $error("kmer: column out of range");

    // Input stalls only while a result waits on a stalled sink
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("kmer: input stalled without output backpressure");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_key_down) && $stable(i_key_row)
             && $stable(i_key_col)))
        else $error("kmer: stalled result changed");

endmodule

bind key_matrix_edge_repeat_unit kmer_checker u_kmer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_key_down  (o_out.key_down),
    .i_key_row   (o_out.key_row),
    .i_key_col   (o_out.key_col)
);
